FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BLOCK_BITS  = 512;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// one block handed from the front to the compression engine
	typedef struct packed {
		logic [BLOCK_BITS-1:0] blk;
		logic                  last;
	} job_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

FILE: rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// collects message bytes into blocks, appends pad and length at end
// ----------------------------------------------------------------------------
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              byte_valid,
	input  logic              end_of_message,
	output logic              job_push,
	output sha_pkg::job_t     job,
	input  logic              job_ready
);

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_PAD    = 1'b1;

	logic         state_q;
	logic [503:0] blk_q;
	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic         pad_sent_q;
	logic         len_flag_q;

	logic         push;
	logic [7:0]   pbyte;
	logic         len_active;
	logic [63:0]  bits;
	logic [5:0]   bsel;
	logic         accepted;

	assign bits       = {len_q, 3'b000};
	assign bsel       = {~fill_q[2:0], 3'b000};
	assign len_active = pad_sent_q && (len_flag_q || fill_q == sha_pkg::LEN_POS);
	assign in_ready   = (state_q == ST_ACCEPT) && (fill_q != sha_pkg::LAST_POS || job_ready);
	assign accepted   = in_valid && in_ready;

	always_comb begin
		if (state_q == ST_ACCEPT) begin
			push  = accepted && byte_valid;
			pbyte = data_byte;
		end else begin
			push = (fill_q != sha_pkg::LAST_POS) || job_ready;
			if (!pad_sent_q)
				pbyte = sha_pkg::PAD_BYTE;
			else if (len_active)
				pbyte = bits[bsel +: 8];
			else
				pbyte = 8'h00;
		end
	end

	assign job_push = push && (fill_q == sha_pkg::LAST_POS);
	assign job.blk  = {blk_q, pbyte};
	assign job.last = (state_q == ST_PAD) && len_active;

	always_ff @(posedge clk) begin
		if (push)
			blk_q <= {blk_q[495:0], pbyte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACCEPT;
			fill_q     <= '0;
			len_q      <= '0;
			pad_sent_q <= 1'b0;
			len_flag_q <= 1'b0;
		end else begin
			if (push)
				fill_q <= fill_q + 6'd1;
			if (accepted) begin
				if (byte_valid)
					len_q <= len_q + 61'd1;
				if (end_of_message) begin
					state_q    <= ST_PAD;
					pad_sent_q <= 1'b0;
					len_flag_q <= 1'b0;
				end
			end
			if (state_q == ST_PAD && push) begin
				pad_sent_q <= 1'b1;
				if (pad_sent_q && fill_q == sha_pkg::LEN_POS)
					len_flag_q <= 1'b1;
				if (job_push && job.last) begin
					state_q    <= ST_ACCEPT;
					len_q      <= '0;
					len_flag_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// small block queue between front and compression engine
// ----------------------------------------------------------------------------
module sha_queue #(
	parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sha_pkg::job_t wdata,
	output logic          ready,
	output logic          valid,
	input  logic          pop,
	output sha_pkg::job_t rdata
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);

	sha_pkg::job_t mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign ready = cnt_q != DEPTH[AW:0];
	assign valid = cnt_q != '0;
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, ready)
	`ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, valid)
	`ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

FILE: rtl/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// one-round-per-cycle compression and digest output
// ----------------------------------------------------------------------------
module sha_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  sha_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last_word
);

	`include "assert_macros.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam logic [31:0] K [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	function automatic logic [31:0] ror(input logic [31:0] x, input int r);
		ror = (x >> r) | (x << (32 - r));
	endfunction

	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        last_q;
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];

	logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2, wnew;

	always_comb begin
		big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + ch + K[rnd_q] + w_q[0];
		big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
		s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
	end

	assign job_pop     = (state_q == ST_IDLE) && job_valid;
	assign out_valid   = state_q == ST_OUT;
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = idx_q == 3'd7;

	// working variables and schedule window
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					for (int i = 0; i < 16; i++)
						w_q[i] <= job.blk[511 - 32*i -: 32];
					for (int i = 0; i < 8; i++)
						v_q[i] <= chain_q[i];
				end
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++)
					w_q[i] <= w_q[i+1];
				w_q[15] <= wnew;
				v_q[7]  <= v_q[6];
				v_q[6]  <= v_q[5];
				v_q[5]  <= v_q[4];
				v_q[4]  <= v_q[3] + t1;
				v_q[3]  <= v_q[2];
				v_q[2]  <= v_q[1];
				v_q[1]  <= v_q[0];
				v_q[0]  <= t1 + t2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < 8; i++)
				chain_q[i] <= sha_pkg::INIT_HASH[i];
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						last_q  <= job.last;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[i] <= chain_q[i] + v_q[i];
					idx_q   <= '0;
					state_q <= last_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								chain_q[i] <= sha_pkg::INIT_HASH[i];
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_rounds_end, clk, arst_n, state_q == ST_ROUND && rnd_q == 6'd63,
		state_q == ST_ADD)
	`ASSERT_NEXT(a_digest_done, clk, arst_n, out_valid && out_ready && last_word,
		state_q == ST_IDLE && chain_q[0] == sha_pkg::INIT_HASH[0])
	`ASSERT_NEXT(a_mid_block, clk, arst_n, state_q == ST_ADD && !last_q, state_q == ST_IDLE)

endmodule

FILE: rtl/sha256_stream_hasher_core.sv
// intake: a byte beat is taken when in_valid and in_ready are both high; the compression
//   engine does load, 64 rounds and chaining add per block, one round per cycle
// throughput: up to one beat per cycle outside padding while the queue has room;
//   the sustained rate is set by the single round unit
// end of message: front adds pad byte, zeros and 64-bit length, then 8 digest beats
// reset: chaining words to the initial hash, counters and queue cleared, buffer undefined
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// sha-256 over a byte stream, digest out as eight 32-bit beats
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core #(
	parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats: one optional byte, optional end of message
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	// digest beats, most significant word first
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// full blocks travel from the byte collector to the round engine
	sha_pkg::job_t push_job;
	sha_pkg::job_t pop_job;
	logic          job_push;
	logic          job_ready;
	logic          job_valid;
	logic          job_pop;

	// front: byte collection, padding and length append
	sha_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.job_push       (job_push),
		.job            (push_job),
		.job_ready      (job_ready)
	);

	// block queue lets the front keep filling while rounds run
	sha_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (push_job),
		.ready  (job_ready),
		.valid  (job_valid),
		.pop    (job_pop),
		.rdata  (pop_job)
	);

	// back: compression rounds and digest beats
	sha_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_pop     (job_pop),
		.job         (pop_job),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
